[hw/rtl/wlcl_pkg.sv]
// ----------------------------------------------------------------------------
// Wear-leveled counter log package
// Types, constants and the page check function shared by the log unit and
// its page store.
// ----------------------------------------------------------------------------
package wlcl_pkg;

   localparam logic [31:0] END_MARKER   = 32'hFFFF_FFFF;
   localparam logic [31:0] BAD_READ     = 32'h0000_FFFF;
   localparam logic [7:0]  ERASED_CHECK = 8'hFF;
   localparam int          PAGE_IDX_W   = 9;

   localparam logic KIND_APPEND  = 1'b0;
   localparam logic KIND_RECOVER = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [31:0] new_value;
   } req_type;

   typedef struct packed {
      logic [31:0]           latest_value;
      logic [PAGE_IDX_W-1:0] latest_page;
      logic                  check_failed;
      logic                  marker_found;
   } rsp_type;

   typedef struct packed {
      logic [31:0] word;
      logic [7:0]  check;
   } page_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_APPEND,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Modulo-256 sum of the four bytes of a word.
   function automatic logic [7:0] byte_sum(input logic [31:0] w);
      byte_sum = w[7:0] + w[15:8] + w[23:16] + w[31:24];
   endfunction

endpackage

[hw/rtl/wlcl_page_store.sv]
// ----------------------------------------------------------------------------
// Wear-leveled counter log page store
// One write port and one read port; read data is registered, so it appears
// in the cycle after the read is issued.
// ----------------------------------------------------------------------------
module wlcl_page_store
   import wlcl_pkg::*;
#(
   parameter int PAGE_COUNT = 512,
   parameter int ADDR_W     = 9
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  page_type          wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output page_type          rd_data
);

   page_type mem [PAGE_COUNT];
   page_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/wear_leveled_counter_log_unit.sv]
// ----------------------------------------------------------------------------
// Wear-leveled counter log unit
// Circular log of 32-bit counter values kept in a page store with a check
// byte per page.
//
// The req_ channel carries one command per transfer: an append (kind 0)
// writes new_value at the write pointer and an end marker on the next page;
// a recover (kind 1) scans the store from page 0 and returns one rsp_
// transfer with the last value before the first end marker.
// An append writes the value in ST_IDLE and the end marker in ST_APPEND,
// one store write per page, since the store has one write port. A recover
// issues the read of page 0 when accepted, then in each ST_SCAN step checks
// one page and issues the next read (up to PAGE_COUNT pages), then loads the
// response register in ST_DONE, as the page store has a single read port.
// After reset the store is erased one page per cycle; req_ready stays low
// until every page is erased. The result waits in an output register;
// appends are still taken while it is stalled, and a recover that finishes
// during a stall holds until rsp_ready frees the register.
// ----------------------------------------------------------------------------
module wear_leveled_counter_log_unit
   import wlcl_pkg::*;
#(
   parameter int PAGE_COUNT = 512
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int ADDR_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam logic [ADDR_W-1:0] LAST_PAGE = ADDR_W'(PAGE_COUNT - 1);

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] wp_ff, wp_in;
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [31:0]       latest_val_ff, latest_val_in;
   logic [ADDR_W-1:0] latest_pg_ff, latest_pg_in;
   logic              bad_ff, bad_in;
   logic              found_ff, found_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;
   logic              rsp_load;

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   page_type          wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   page_type          rd_data;

   logic              page_ok;
   logic [31:0]       page_val;
   logic [ADDR_W-1:0] wp_eff;

   wlcl_page_store #(
      .PAGE_COUNT (PAGE_COUNT),
      .ADDR_W     (ADDR_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // A page whose check byte disagrees reads as a fixed bad value.
   assign page_ok  = (rd_data.check == byte_sum(rd_data.word));
   assign page_val = page_ok ? rd_data.word : BAD_READ;
   assign wp_eff   = (wp_ff == LAST_PAGE) ? '0 : wp_ff;

   always_comb begin
      state_in      = state_ff;
      wp_in         = wp_ff;
      idx_in        = idx_ff;
      latest_val_in = latest_val_ff;
      latest_pg_in  = latest_pg_ff;
      bad_in        = bad_ff;
      found_in      = found_ff;
      rsp_load      = 1'b0;
      req_ready     = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = idx_ff;
      wr_data       = '{word: END_MARKER, check: ERASED_CHECK};
      rd_en         = 1'b0;
      rd_addr       = '0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = idx_ff;
            wr_data = '{word: END_MARKER, check: ERASED_CHECK};
            if (idx_ff == LAST_PAGE) begin
               idx_in   = '0;
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + ADDR_W'(1);
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_data.kind == KIND_APPEND) begin
                  wr_en    = 1'b1;
                  wr_addr  = wp_eff;
                  wr_data  = '{word: req_data.new_value,
                               check: byte_sum(req_data.new_value)};
                  wp_in    = wp_eff + ADDR_W'(1);
                  state_in = ST_APPEND;
               end else begin
                  rd_en         = 1'b1;
                  rd_addr       = '0;
                  idx_in        = '0;
                  latest_val_in = '0;
                  latest_pg_in  = '0;
                  bad_in        = 1'b0;
                  found_in      = 1'b0;
                  state_in      = ST_SCAN;
               end
            end
         end
         ST_APPEND: begin
            // The pointer already moved to the page after the value.
            wr_en    = 1'b1;
            wr_addr  = wp_ff;
            wr_data  = '{word: END_MARKER, check: byte_sum(END_MARKER)};
            state_in = ST_IDLE;
         end
         ST_SCAN: begin
            // The read data belongs to page idx_ff; the next read goes out now.
            bad_in = bad_ff | ~page_ok;
            if (page_val == END_MARKER) begin
               found_in = 1'b1;
               wp_in    = idx_ff;
               state_in = ST_DONE;
            end else begin
               latest_val_in = page_val;
               latest_pg_in  = idx_ff;
               if (idx_ff == LAST_PAGE) begin
                  found_in = 1'b0;
                  wp_in    = idx_ff;
                  state_in = ST_DONE;
               end else begin
                  rd_en   = 1'b1;
                  rd_addr = idx_ff + ADDR_W'(1);
                  idx_in  = idx_ff + ADDR_W'(1);
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_ready);

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (rsp_load) begin
         rsp_data_in.latest_value = latest_val_ff;
         rsp_data_in.latest_page  = PAGE_IDX_W'(latest_pg_ff);
         rsp_data_in.check_failed = bad_ff;
         rsp_data_in.marker_found = found_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         wp_ff        <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      latest_val_ff <= latest_val_in;
      latest_pg_ff  <= latest_pg_in;
      bad_ff        <= bad_in;
      found_ff      <= found_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// Counter log unit testbench
// Sends append and recover commands to the log unit with random gaps on both
// channels. A model of the page store inside the testbench predicts each
// recover result, and every rsp_ transfer is compared field by field.
// ----------------------------------------------------------------------------
module testbench;
   import wlcl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAGE_COUNT    = 512;
   localparam int SETTLE_CYCLES = PAGE_COUNT + 8;
   localparam int RUN_LIMIT     = 3_000_000;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // Mirror of the page store and write pointer.
   logic [31:0] log_word [PAGE_COUNT];
   logic [7:0]  log_check [PAGE_COUNT];
   int unsigned log_pointer;
   int          wrap_count;

   rsp_type expected_recoveries[$];
   rsp_type next_recovery;
   int      error_count;
   int      cycle_count;
   bit      req_quiet;
   bit      rsp_quiet;

   wear_leveled_counter_log_unit #(
      .PAGE_COUNT(PAGE_COUNT)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   function automatic logic [7:0] sum_bytes(input logic [31:0] w);
      logic [7:0] acc;
      acc = '0;
      for (int i = 0; i < 4; i++)
         acc += w[8*i +: 8];
      return acc;
   endfunction

   function automatic void write_page(input int unsigned p, input logic [31:0] w);
      if (p < PAGE_COUNT) begin
         log_word[p]  = w;
         log_check[p] = sum_bytes(w);
      end
   endfunction

   // Updates the store mirror for one accepted command and queues the
   // result that a recover must produce.
   function automatic void apply_command(input logic kind, input logic [31:0] value);
      rsp_type     result;
      logic [31:0] w;
      int unsigned p;
      bit          stop;
      if (kind == KIND_APPEND) begin
         if (log_pointer >= PAGE_COUNT - 1) begin
            log_pointer = 0;
            wrap_count++;
         end
         write_page(log_pointer, value);
         write_page(log_pointer + 1, END_MARKER);
         log_pointer++;
      end else begin
         result = '0;
         stop   = 1'b0;
         p      = 0;
         while (!stop && p < PAGE_COUNT) begin
            // A page with a bad check byte reads back as BAD_READ and sets check_failed.
            if (sum_bytes(log_word[p]) != log_check[p]) begin
               w = BAD_READ;
               result.check_failed = 1'b1;
            end else begin
               w = log_word[p];
            end
            log_pointer = p;
            if (w == END_MARKER) begin
               result.marker_found = 1'b1;
               stop = 1'b1;
            end else begin
               result.latest_value = w;
               result.latest_page  = p[PAGE_IDX_W-1:0];
               p++;
            end
         end
         expected_recoveries.push_back(result);
      end
   endfunction

   function automatic logic [31:0] draw_value();
      case ($urandom_range(0, 63))
         0:       return END_MARKER;
         1:       return BAD_READ;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFE;
         4:       return 32'h1 << $urandom_range(0, 31);
         default: return $urandom;
      endcase
   endfunction

   function automatic void report_field(input string field, input logic [31:0] want,
                                        input logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %h actual %h", $time, field, want, got);
         error_count++;
      end
   endfunction

   // Result checker.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_ready) begin
         if (expected_recoveries.size() == 0) begin
            $display("%0t: unexpected result expected none actual %h", $time, rsp_data);
            error_count++;
         end else begin
            next_recovery = expected_recoveries.pop_front();
            report_field("latest_value", next_recovery.latest_value, rsp_data.latest_value);
            report_field("latest_page", 32'(next_recovery.latest_page),
                         32'(rsp_data.latest_page));
            report_field("check_failed", 32'(next_recovery.check_failed),
                         32'(rsp_data.check_failed));
            report_field("marker_found", 32'(next_recovery.marker_found),
                         32'(rsp_data.marker_found));
         end
      end
   end

   // Result receiver: a random stall before each transfer unless rsp_quiet is set.
   initial begin
      int stall;
      @(posedge clock);
      forever begin
         stall = rsp_quiet ? 0 : $urandom_range(0, 15);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // Sends one command. On return valid is still high; the next call either
   // replaces the payload or lowers valid for its gap.
   task automatic send_item(input logic kind, input logic [31:0] value);
      req_type item;
      int      gap;
      item.kind      = kind;
      item.new_value = value;
      gap = req_quiet ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      apply_command(kind, value);
   endtask

   // Holds the sender off until every predicted result has been checked.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (expected_recoveries.size() != 0);
   endtask

   // Fresh store: every page is erased, so nothing reads as a marker and the
   // next append wraps to page 0.
   task automatic test_erased_store();
      send_item(KIND_RECOVER, 32'h0000_0000);
      send_item(KIND_APPEND, 32'h0000_0000);
      send_item(KIND_RECOVER, 32'hFFFF_FFFF);
      send_item(KIND_RECOVER, $urandom);
      drain_results();
   endtask

   // Appended values that look like the marker or like a failed read.
   task automatic test_marker_values();
      send_item(KIND_APPEND, END_MARKER);
      send_item(KIND_RECOVER, $urandom);
      send_item(KIND_APPEND, BAD_READ);
      send_item(KIND_APPEND, 32'h8000_0001);
      send_item(KIND_APPEND, 32'h7FFF_FFFE);
      send_item(KIND_APPEND, 32'hFFFF_FFFE);
      send_item(KIND_APPEND, 32'hA5A5_5A5A);
      send_item(KIND_APPEND, 32'h5A5A_A5A5);
      send_item(KIND_RECOVER, $urandom);
      send_item(KIND_APPEND, END_MARKER);
      send_item(KIND_APPEND, 32'h0000_0001);
      send_item(KIND_RECOVER, $urandom);
      send_item(KIND_RECOVER, $urandom);
      drain_results();
   endtask

   // Runs of appends closed by a recover, with stray back-to-back recovers.
   task automatic test_random_log(input int item_total);
      int sent;
      int appends;
      sent = 0;
      while (sent < item_total) begin
         req_quiet = ($urandom_range(0, 4) == 0);
         rsp_quiet = ($urandom_range(0, 4) == 0);
         appends = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 14);
         repeat (appends) send_item(KIND_APPEND, draw_value());
         send_item(KIND_RECOVER, $urandom);
         sent += appends + 1;
         if ($urandom_range(0, 7) == 0) begin
            send_item(KIND_RECOVER, $urandom);
            sent++;
         end
         if ($urandom_range(0, 15) == 0)
            drain_results();
      end
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
      drain_results();
   endtask

   // Appends until the write pointer runs off the last page and wraps.
   task automatic test_pointer_wrap();
      int wraps_seen;
      wraps_seen = wrap_count;
      req_quiet = ($urandom_range(0, 1) == 0);
      while (wrap_count == wraps_seen)
         send_item(KIND_APPEND, draw_value());
      req_quiet = 1'b0;
      repeat (3) send_item(KIND_APPEND, draw_value());
      send_item(KIND_RECOVER, $urandom);
      send_item(KIND_RECOVER, $urandom);
      drain_results();
   endtask

   initial begin
      for (int p = 0; p < PAGE_COUNT; p++) begin
         log_word[p]  = END_MARKER;
         log_check[p] = ERASED_CHECK;
      end
      log_pointer = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_erased_store();
      test_marker_values();
      test_random_log(120);
      test_pointer_wrap();
      test_random_log(40);

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

[wear_leveled_counter_log_unit.f]
hw/rtl/wlcl_pkg.sv
hw/rtl/wlcl_page_store.sv
hw/rtl/wear_leveled_counter_log_unit.sv
tb/testbench.sv
